@@ design/pmsm_pkg.sv @@
// Shared types and constants for the pair merge score block.
// No dependencies; imported by every module of the block.
package pmsm_pkg;

    localparam int HIDDEN_DIM_DEF = 64;
    localparam int K_MAX_W        = 11;   // column index width for up to 2048 joint elements
    localparam int ACC_W          = 48;   // exact hidden pre-activation sum
    localparam int SCORE_W        = 48;   // exact score sum

    typedef enum logic [1:0] {
        CMD_WEIGHT  = 2'd0,
        CMD_BIAS    = 2'd1,
        CMD_SWEIGHT = 2'd2,
        CMD_FEATURE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        cmd_t               command;
        logic [12:0]        index;
        logic signed [15:0] value;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic               saturated;
    } out_item_t;

    // Joint element travelling down the cell row.
    typedef struct packed {
        logic               valid;
        logic               first;
        logic               lastk;
        logic [K_MAX_W-1:0] k;
        logic signed [15:0] j;
    } tok_t;

    // Partial score travelling down the cell row.
    typedef struct packed {
        logic                      valid;
        logic                      sat;
        logic signed [SCORE_W-1:0] sum;
    } link_t;

endpackage

@@ design/pmsm_cell.sv @@
// One hidden unit: weight row memory, bias, score weight, MAC and score link.
// Depends on pmsm_pkg.
module pmsm_cell
    import pmsm_pkg::*;
#(
    parameter int HIDDEN_DIM = HIDDEN_DIM_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     wr_en,
    input  in_item_t wr_item,
    input  tok_t     tok_in,
    output tok_t     tok_out,
    input  link_t    link_in,
    output link_t    link_out
);

    localparam int JOINT_DIM = 2 * HIDDEN_DIM;
    localparam int CW        = (JOINT_DIM > 1) ? $clog2(JOINT_DIM) : 1;
    localparam int ROW_BASE  = CELL_IDX * JOINT_DIM;

    logic signed [15:0] wmem [JOINT_DIM];
    logic signed [15:0] w_reg;
    logic signed [15:0] bias_reg;
    logic signed [15:0] sw_reg;
    tok_t               a_reg;
    logic signed [31:0] prod_reg;
    logic               b_valid_reg, b_first_reg, b_last_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic               c_last_reg;
    logic [14:0]        h_reg;
    logic               hsat_reg, d_valid_reg;
    logic signed [32:0] sp_reg;
    logic               e_valid_reg, e_sat_reg;
    link_t              out_reg;

    logic               in_row;
    logic [CW-1:0]      col;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd;
    logic [14:0]        h_next;
    logic               hsat_next;

    always_comb begin
        in_row = (int'(wr_item.index) >= ROW_BASE) &&
                 (int'(wr_item.index) < ROW_BASE + JOINT_DIM);
        col    = CW'(int'(wr_item.index) - ROW_BASE);
    end

    // store writes
    always_ff @(posedge aclk) begin
        if (wr_en && wr_item.command == CMD_WEIGHT && in_row) begin
            wmem[col] <= wr_item.value;
        end
        if (wr_en && wr_item.command == CMD_BIAS && int'(wr_item.index) == CELL_IDX) begin
            bias_reg <= wr_item.value;
        end
        if (wr_en && wr_item.command == CMD_SWEIGHT && int'(wr_item.index) == CELL_IDX) begin
            sw_reg <= wr_item.value;
        end
        w_reg <= wmem[tok_in.k[CW-1:0]];
    end

    always_comb begin
        if (b_first_reg) begin
            acc_next = (ACC_W'(bias_reg) <<< 12) + ACC_W'(prod_reg);
        end else begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
        // ReLU, round half up, clamp to Q4.12
        rnd       = (acc_reg + ACC_W'(2048)) >>> 12;
        h_next    = '0;
        hsat_next = 1'b0;
        if (acc_reg > 0) begin
            if (rnd > ACC_W'(32767)) begin
                h_next    = 15'h7fff;
                hsat_next = 1'b1;
            end else begin
                h_next = rnd[14:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg.valid   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_last_reg    <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_reg.valid <= 1'b0;
        end else begin
            a_reg.valid   <= tok_in.valid;
            b_valid_reg   <= a_reg.valid;
            c_last_reg    <= b_valid_reg && b_last_reg;
            d_valid_reg   <= c_last_reg;
            e_valid_reg   <= d_valid_reg;
            out_reg.valid <= e_valid_reg;
        end
        a_reg.first <= tok_in.first;
        a_reg.lastk <= tok_in.lastk;
        a_reg.k     <= tok_in.k;
        a_reg.j     <= tok_in.j;
        prod_reg    <= w_reg * a_reg.j;
        b_first_reg <= a_reg.first;
        b_last_reg  <= a_reg.lastk;
        if (b_valid_reg) begin
            acc_reg <= acc_next;
        end
        h_reg       <= h_next;
        hsat_reg    <= hsat_next;
        sp_reg      <= $signed({2'b00, h_reg}) * sw_reg;
        e_sat_reg   <= hsat_reg;
        out_reg.sum <= link_in.sum + SCORE_W'(sp_reg);
        out_reg.sat <= link_in.sat | e_sat_reg;
    end

    assign tok_out  = a_reg;
    assign link_out = out_reg;

endmodule

@@ design/pair_merge_score_mlp_core.sv @@
// Top level of the pair merge score block: sequencer, joint buffer, cell row.
// Depends on pmsm_pkg and pmsm_cell.
//
// Usage:
//   s_ channel (valid/ready) carries load and feature transactions. Weight,
//   bias and score weight loads go straight into the per-unit cells; feature
//   elements go into the joint buffer. A feature transaction with last set
//   starts a scoring: joint elements are streamed down a row of HIDDEN_DIM
//   cells, one element per cycle, each cell doing one MAC per cycle on its
//   own weight row. The result is ready once the joint vector has been
//   issued, has rippled down the row and has passed the cell and output
//   stages; m_valid rises when it moves to the output register. s_ready is
//   low until the result moves to the output register, so the next
//   transaction is taken only after that.
//   m_ channel carries one transaction per scoring: saturated Q8.24 score and
//   a flag. The result sits in an output register; while it waits for
//   m_ready, new loads and features are still taken, and a following scoring
//   may run; its result waits in a holding stage until the output frees up.
//   aresetn (synchronous, active low) clears all control state; the stores
//   hold garbage until written.
module pair_merge_score_mlp_core
    import pmsm_pkg::*;
#(
    parameter int HIDDEN_DIM = HIDDEN_DIM_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int JOINT_DIM = 2 * HIDDEN_DIM;
    localparam int CW        = (JOINT_DIM > 1) ? $clog2(JOINT_DIM) : 1;

    state_t             state_reg, state_next;
    logic [CW-1:0]      k_reg, k_next;
    logic               accept;
    logic               tv_reg, tv_next, tf_reg, tf_next, tl_reg, tl_next;
    logic [CW-1:0]      tk_reg;
    logic signed [15:0] jmem [JOINT_DIM];
    logic signed [15:0] jdata_reg;
    out_item_t          pend_reg, pend_next;
    logic               pend_load;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg;
    logic               out_load;

    tok_t  toks  [HIDDEN_DIM+1];
    link_t links [HIDDEN_DIM+1];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    // joint buffer
    always_ff @(posedge aclk) begin
        if (accept && s_data.command == CMD_FEATURE && int'(s_data.index) < JOINT_DIM) begin
            jmem[s_data.index[CW-1:0]] <= s_data.value;
        end
        jdata_reg <= jmem[k_reg];
        tk_reg    <= k_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        tv_next    = 1'b0;
        tf_next    = 1'b0;
        tl_next    = 1'b0;
        pend_load  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                k_next = '0;
                if (accept && s_data.command == CMD_FEATURE && s_data.last) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                tv_next = 1'b1;
                tf_next = (k_reg == '0);
                tl_next = (int'(k_reg) == JOINT_DIM - 1);
                k_next  = k_reg + 1'b1;
                if (tl_next) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (links[HIDDEN_DIM].valid) begin
                    pend_load  = 1'b1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            tv_reg    <= tv_next;
        end
        k_reg  <= k_next;
        tf_reg <= tf_next;
        tl_reg <= tl_next;
    end

    always_comb begin
        toks[0].valid = tv_reg;
        toks[0].first = tf_reg;
        toks[0].lastk = tl_reg;
        toks[0].k     = K_MAX_W'(tk_reg);
        toks[0].j     = jdata_reg;
        links[0]      = '0;
    end

    // row of hidden-unit cells
    for (genvar n = 0; n < HIDDEN_DIM; n++) begin : g_cell
        pmsm_cell #(
            .HIDDEN_DIM (HIDDEN_DIM),
            .CELL_IDX   (n)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .wr_en    (accept),
            .wr_item  (s_data),
            .tok_in   (toks[n]),
            .tok_out  (toks[n+1]),
            .link_in  (links[n]),
            .link_out (links[n+1])
        );
    end

    // clamp the exact score to 32 bits
    always_comb begin
        pend_next.saturated = links[HIDDEN_DIM].sat;
        if (links[HIDDEN_DIM].sum > SCORE_W'(64'sh7fffffff)) begin
            pend_next.score     = 32'sh7fffffff;
            pend_next.saturated = 1'b1;
        end else if (links[HIDDEN_DIM].sum < -SCORE_W'(64'sh80000000)) begin
            pend_next.score     = 32'sh80000000;
            pend_next.saturated = 1'b1;
        end else begin
            pend_next.score = links[HIDDEN_DIM].sum[31:0];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (pend_load) begin
            pend_reg <= pend_next;
        end
        if (out_load) begin
            m_data_reg <= pend_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
